// ----- rtl/vfc_pkg.sv -----
`default_nettype none

package vfc_pkg;

   // Default chunk geometry.
   localparam int CHUNK_SIDE_DEFAULT = 16;
   localparam int CHUNK_TALL_DEFAULT = 64;

   // Request codes.
   localparam logic [1:0] REQ_COLUMN = 2'd0;
   localparam logic [1:0] REQ_EDGE   = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;

   // Neighbor sides, also the bit positions of the presence register.
   localparam logic [1:0] SIDE_XN = 2'd0;
   localparam logic [1:0] SIDE_XP = 2'd1;
   localparam logic [1:0] SIDE_ZN = 2'd2;
   localparam logic [1:0] SIDE_ZP = 2'd3;

   // Bit positions in the face mask.
   localparam int FACE_FRONT  = 0;
   localparam int FACE_BACK   = 1;
   localparam int FACE_LEFT   = 2;
   localparam int FACE_RIGHT  = 3;
   localparam int FACE_TOP    = 4;
   localparam int FACE_BOTTOM = 5;

endpackage

`default_nettype wire

// ----- rtl/vfc_bank.sv -----
`default_nettype none

// One bank of the column height store: one write port, two read ports,
// registered read data that holds while no read is enabled.
module vfc_bank #(
   parameter int DEPTH = 128,
   parameter int AW    = 7,
   parameter int DW    = 7
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] raddr_a,
   input  wire logic [AW-1:0] raddr_b,
   output logic      [DW-1:0] rdata_a,
   output logic      [DW-1:0] rdata_b
);

   logic [DW-1:0] store_ff [DEPTH];
   logic [DW-1:0] rdata_a_ff;
   logic [DW-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_a_ff <= store_ff[raddr_a];
         rdata_b_ff <= store_ff[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

`default_nettype wire

// ----- rtl/vfc_edge_ram.sv -----
`default_nettype none

// Neighbor edge height store: one write port, one read port, registered
// read data that holds while no read is enabled.
module vfc_edge_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 7
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] raddr,
   output logic      [DW-1:0] rdata
);

   logic [DW-1:0] store_ff [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/voxel_face_culling.sv -----
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_type, req_col_x, req_col_z, req_voxel_y,
//                                             req_height, req_side, req_edge_pos
// rsp       out        rsp_valid/rsp_ready    rsp_solid, rsp_face_mask
// csr       in         csr_valid/csr_ready    csr_neighbour_present
//
// A query needs five column heights, read in two rounds from the two read ports of the
// column banks. After reset a clearing pass zeroes both stores, and no request is
// taken meanwhile.
// A result waits in the output register; a query stalls in its last cycle only while
// that register is still full and not being taken.

module voxel_face_culling #(
   parameter int CHUNK_SIDE = vfc_pkg::CHUNK_SIDE_DEFAULT,
   parameter int CHUNK_TALL = vfc_pkg::CHUNK_TALL_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_type,
   input  wire logic [3:0] req_col_x,
   input  wire logic [3:0] req_col_z,
   input  wire logic [5:0] req_voxel_y,
   input  wire logic [6:0] req_height,
   input  wire logic [1:0] req_side,
   input  wire logic [3:0] req_edge_pos,

   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_solid,
   output logic      [5:0] rsp_face_mask,

   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [3:0] csr_neighbour_present
);

   import vfc_pkg::*;

   // Geometry. Columns are split over two banks by the parity of x + z, so that the
   // four horizontal neighbors of a column all sit in the bank opposite to it. The
   // bank address is the linear column index divided by two.
   localparam int IDX_W       = $clog2(CHUNK_SIDE);
   localparam int LIN_W       = $clog2(CHUNK_SIDE * CHUNK_SIDE);
   localparam int BANK_DEPTH  = (CHUNK_SIDE * CHUNK_SIDE + 1) / 2;
   localparam int BANK_AW     = LIN_W - 1;
   localparam int EDGE_DEPTH  = 4 * CHUNK_SIDE;
   localparam int EDGE_AW     = $clog2(EDGE_DEPTH);
   localparam int HW          = $clog2(CHUNK_TALL + 1);
   localparam int CMP_W       = ((HW > 7) ? HW : 7) + 1;
   localparam int CLR_LEN     = (BANK_DEPTH > EDGE_DEPTH) ? BANK_DEPTH : EDGE_DEPTH;
   localparam int CLR_W       = $clog2(CLR_LEN);

   // Sequencer states.
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RD1   = 2'd2;
   localparam logic [1:0] ST_EVAL  = 2'd3;

   function automatic logic [BANK_AW-1:0] bank_addr(input logic [IDX_W-1:0] cx,
                                                    input logic [IDX_W-1:0] cz);
      logic [LIN_W-1:0] lin;
      lin = LIN_W'(cz) * LIN_W'(CHUNK_SIDE) + LIN_W'(cx);
      return lin[LIN_W-1:1];
   endfunction

   function automatic logic [EDGE_AW-1:0] edge_addr(input logic [1:0]       sd,
                                                    input logic [IDX_W-1:0] pos);
      return EDGE_AW'(sd) * EDGE_AW'(CHUNK_SIDE) + EDGE_AW'(pos);
   endfunction

   logic [1:0]       state_ff, state_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   logic [3:0]       present_ff;

   // Query context, latched when the query is taken.
   logic [IDX_W-1:0] x_ff, z_ff;
   logic [5:0]       y_ff;
   logic             par_ff;
   logic             ok_ff;

   // Heights captured from the first read round.
   logic [HW-1:0]    here_ff, front_ff, back_ff, edge_z_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_solid_ff;
   logic [5:0]       rsp_face_ff;

   logic             clearing;
   logic             accept;
   logic             q_start;
   logic             col_wr;
   logic             edge_wr;
   logic             out_free;
   logic             load;
   logic [IDX_W-1:0] p0_x, p0_z;
   logic             p0_par;
   logic             p0_ok;
   logic [HW-1:0]    sat_height;

   logic             bank_we      [2];
   logic             bank_rd_en   [2];
   logic [BANK_AW-1:0] bank_raddr_a [2];
   logic [BANK_AW-1:0] bank_raddr_b [2];
   logic [HW-1:0]    bank_rdata_a [2];
   logic [HW-1:0]    bank_rdata_b [2];
   logic [BANK_AW-1:0] bank_waddr;
   logic [HW-1:0]    bank_wdata;

   logic             edge_we;
   logic [EDGE_AW-1:0] edge_waddr;
   logic [HW-1:0]    edge_wdata;
   logic             edge_rd_en;
   logic [EDGE_AW-1:0] edge_raddr;
   logic [HW-1:0]    edge_rdata;

   logic [HW-1:0]    left_h, right_h;
   logic [5:0]       hide;
   logic             solid;
   logic [CMP_W-1:0] yv;

   assign clearing  = (state_ff == ST_CLEAR);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_EVAL) && out_free);
   assign accept    = req_valid && req_ready;
   assign q_start   = accept && (req_type == REQ_QUERY);
   assign load      = (state_ff == ST_EVAL) && out_free;
   assign csr_ready = 1'b1;

   // The incoming item's column, used for writes and for the first read round.
   assign p0_x   = IDX_W'(req_col_x);
   assign p0_z   = IDX_W'(req_col_z);
   assign p0_par = req_col_x[0] ^ req_col_z[0];
   assign p0_ok  = (32'(req_col_x) < CHUNK_SIDE) && (32'(req_col_z) < CHUNK_SIDE) &&
                   (32'(req_voxel_y) < CHUNK_TALL);

   assign col_wr  = accept && (req_type == REQ_COLUMN) &&
                    (32'(req_col_x) < CHUNK_SIDE) && (32'(req_col_z) < CHUNK_SIDE);
   assign edge_wr = accept && (req_type == REQ_EDGE) && (32'(req_edge_pos) < CHUNK_SIDE);

   // Heights above the chunk top are stored as the chunk top.
   assign sat_height = (32'(req_height) > CHUNK_TALL) ? HW'(CHUNK_TALL) : HW'(req_height);

   // Column bank ports. In the first round the query's own bank delivers its height
   // and the opposite bank delivers the front and back neighbors. In the second round
   // the opposite bank delivers the left and right neighbors. Reads whose neighbor lies
   // outside the chunk fetch a don't-care entry that the face logic ignores.
   assign bank_waddr = clearing ? clr_ff[BANK_AW-1:0] : bank_addr(p0_x, p0_z);
   assign bank_wdata = clearing ? '0 : sat_height;

   always_comb begin
      for (int b = 0; b < 2; b++) begin
         bank_we[b] = clearing ? (32'(clr_ff) < BANK_DEPTH) : (col_wr && (1'(b) == p0_par));
         if (state_ff == ST_RD1) begin
            bank_rd_en[b]   = (1'(b) != par_ff);
            bank_raddr_a[b] = bank_addr(x_ff - IDX_W'(1), z_ff);
            bank_raddr_b[b] = bank_addr(x_ff + IDX_W'(1), z_ff);
         end else begin
            bank_rd_en[b] = q_start;
            if (1'(b) == p0_par) begin
               bank_raddr_a[b] = bank_addr(p0_x, p0_z);
               bank_raddr_b[b] = bank_addr(p0_x, p0_z);
            end else begin
               bank_raddr_a[b] = bank_addr(p0_x, p0_z + IDX_W'(1));
               bank_raddr_b[b] = bank_addr(p0_x, p0_z - IDX_W'(1));
            end
         end
      end
   end

   for (genvar g = 0; g < 2; g++) begin : g_bank
      vfc_bank #(
         .DEPTH (BANK_DEPTH),
         .AW    (BANK_AW),
         .DW    (HW)
      ) u_bank (
         .clock   (clock),
         .we      (bank_we[g]),
         .waddr   (bank_waddr),
         .wdata   (bank_wdata),
         .rd_en   (bank_rd_en[g]),
         .raddr_a (bank_raddr_a[g]),
         .raddr_b (bank_raddr_b[g]),
         .rdata_a (bank_rdata_a[g]),
         .rdata_b (bank_rdata_b[g])
      );
   end

   // Edge store port. The first round fetches the z-side edge under the query's x, the
   // second round the x-side edge under its z. Only one of the two z sides can touch a
   // column, so one read a round is enough even at a corner.
   assign edge_we    = clearing ? (32'(clr_ff) < EDGE_DEPTH) : edge_wr;
   assign edge_waddr = clearing ? clr_ff[EDGE_AW-1:0] :
                                  edge_addr(req_side, IDX_W'(req_edge_pos));
   assign edge_wdata = clearing ? '0 : sat_height;
   assign edge_rd_en = q_start || (state_ff == ST_RD1);

   always_comb begin
      if (state_ff == ST_RD1) begin
         edge_raddr = edge_addr((x_ff == '0) ? SIDE_XN : SIDE_XP, z_ff);
      end else begin
         edge_raddr = edge_addr((p0_z == '0) ? SIDE_ZN : SIDE_ZP, p0_x);
      end
   end

   vfc_edge_ram #(
      .DEPTH (EDGE_DEPTH),
      .AW    (EDGE_AW),
      .DW    (HW)
   ) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .waddr (edge_waddr),
      .wdata (edge_wdata),
      .rd_en (edge_rd_en),
      .raddr (edge_raddr),
      .rdata (edge_rdata)
   );

   // Face evaluation, done in the last cycle of a query from the captured first-round
   // heights and the second-round read data still held at the memory outputs.
   assign left_h  = par_ff ? bank_rdata_a[0] : bank_rdata_a[1];
   assign right_h = par_ff ? bank_rdata_b[0] : bank_rdata_b[1];
   assign yv      = CMP_W'(y_ff);
   assign solid   = ok_ff && (yv <= CMP_W'(here_ff));

   always_comb begin
      hide = '0;
      if (32'(z_ff) + 32'd1 < 32'(CHUNK_SIDE)) begin
         hide[FACE_FRONT] = (yv <= CMP_W'(front_ff));
      end else begin
         hide[FACE_FRONT] = present_ff[SIDE_ZP] && (yv <= CMP_W'(edge_z_ff));
      end
      if (z_ff != '0) begin
         hide[FACE_BACK] = (yv <= CMP_W'(back_ff));
      end else begin
         hide[FACE_BACK] = present_ff[SIDE_ZN] && (yv <= CMP_W'(edge_z_ff));
      end
      if (x_ff != '0) begin
         hide[FACE_LEFT] = (yv <= CMP_W'(left_h));
      end else begin
         hide[FACE_LEFT] = present_ff[SIDE_XN] && (yv <= CMP_W'(edge_rdata));
      end
      if (32'(x_ff) + 32'd1 < 32'(CHUNK_SIDE)) begin
         hide[FACE_RIGHT] = (yv <= CMP_W'(right_h));
      end else begin
         hide[FACE_RIGHT] = present_ff[SIDE_XP] && (yv <= CMP_W'(edge_rdata));
      end
      // The top face stays visible at the chunk ceiling.
      hide[FACE_TOP] = (yv + CMP_W'(1) < CMP_W'(CHUNK_TALL)) &&
                       (yv + CMP_W'(1) <= CMP_W'(here_ff));
      // The bottom face is always hidden on the floor of the chunk.
      hide[FACE_BOTTOM] = (y_ff == '0) || (yv - CMP_W'(1) <= CMP_W'(here_ff));
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + CLR_W'(1);
            if (clr_ff == CLR_W'(CLR_LEN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            state_in = q_start ? ST_RD1 : ST_IDLE;
         end
         ST_RD1: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (out_free) begin
               state_in = q_start ? ST_RD1 : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         present_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            present_ff <= csr_neighbour_present;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_start) begin
         x_ff   <= p0_x;
         z_ff   <= p0_z;
         y_ff   <= req_voxel_y;
         par_ff <= p0_par;
         ok_ff  <= p0_ok;
      end
      if (state_ff == ST_RD1) begin
         here_ff   <= par_ff ? bank_rdata_a[1] : bank_rdata_a[0];
         front_ff  <= par_ff ? bank_rdata_a[0] : bank_rdata_a[1];
         back_ff   <= par_ff ? bank_rdata_b[0] : bank_rdata_b[1];
         edge_z_ff <= edge_rdata;
      end
      if (load) begin
         rsp_solid_ff <= solid;
         rsp_face_ff  <= solid ? ~hide : 6'd0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_solid     = rsp_solid_ff;
   assign rsp_face_mask = rsp_face_ff;

endmodule

`default_nettype wire
